>>> hw/rtl/irpd_pkg.sv
// ----------------------------------------------------------------------------
// IR pulse-distance receiver package
// Shared types, constants and helpers for the receiver and its step logic.
// ----------------------------------------------------------------------------
package irpd_pkg;

   localparam int           FRAME_BYTES     = 6;
   localparam logic [3:0]   FRAME_BYTES_CNT = 4'(FRAME_BYTES);
   localparam logic [5:0]   CNT_MAX         = 6'd63;
   localparam logic [5:0]   DATA_HIGH_LIMIT = 6'd8;
   localparam logic [3:0]   BITS_PER_BYTE   = 4'd8;
   localparam int           CSR_AW          = 3;
   localparam int           CSR_DW          = 6;

   // Register indexes
   localparam logic [CSR_AW-1:0] REG_LEADER_LOW_MIN  = 3'd0;
   localparam logic [CSR_AW-1:0] REG_LEADER_LOW_MAX  = 3'd1;
   localparam logic [CSR_AW-1:0] REG_LEADER_HIGH_MIN = 3'd2;
   localparam logic [CSR_AW-1:0] REG_LEADER_HIGH_MAX = 3'd3;
   localparam logic [CSR_AW-1:0] REG_BIT_LOW_MAX     = 3'd4;
   localparam logic [CSR_AW-1:0] REG_ZERO_HIGH_MIN   = 3'd5;
   localparam logic [CSR_AW-1:0] REG_ZERO_HIGH_MAX   = 3'd6;
   localparam logic [CSR_AW-1:0] REG_ONE_HIGH_MIN    = 3'd7;

   // Register reset values
   localparam logic [CSR_DW-1:0] RST_LEADER_LOW_MIN  = 6'd15;
   localparam logic [CSR_DW-1:0] RST_LEADER_LOW_MAX  = 6'd25;
   localparam logic [CSR_DW-1:0] RST_LEADER_HIGH_MIN = 6'd35;
   localparam logic [CSR_DW-1:0] RST_LEADER_HIGH_MAX = 6'd45;
   localparam logic [CSR_DW-1:0] RST_BIT_LOW_MAX     = 6'd4;
   localparam logic [CSR_DW-1:0] RST_ZERO_HIGH_MIN   = 6'd2;
   localparam logic [CSR_DW-1:0] RST_ZERO_HIGH_MAX   = 6'd3;
   localparam logic [CSR_DW-1:0] RST_ONE_HIGH_MIN    = 6'd7;

   typedef enum logic [5:0] {
      PH_IDLE        = 6'b000001,
      PH_LEADER_LOW  = 6'b000010,
      PH_LEADER_HIGH = 6'b000100,
      PH_FIRST_LOW   = 6'b001000,
      PH_DATA        = 6'b010000,
      PH_FRAME_END   = 6'b100000
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [5:0]  low_ticks;
      logic [5:0]  high_ticks;
      logic [3:0]  bit_counter;
      logic [2:0]  byte_counter;
      logic [7:0]  shift_byte;
      logic        bit_taken;
      logic        ready_flag;
   } rx_state_type;

   typedef struct packed {
      logic [5:0] leader_low_min;
      logic [5:0] leader_low_max;
      logic [5:0] leader_high_min;
      logic [5:0] leader_high_max;
      logic [5:0] bit_low_max;
      logic [5:0] zero_high_min;
      logic [5:0] zero_high_max;
      logic [5:0] one_high_min;
   } cfg_type;

   typedef struct packed {
      logic        byte_valid;
      logic [7:0]  byte_value;
      logic [2:0]  byte_index;
      logic        frame_last;
      logic        frame_abort;
      logic        frame_ready;
      logic        receiving;
   } rsp_type;

   // Saturating tick counter increment
   function automatic logic [5:0] sat_inc(input logic [5:0] v);
      sat_inc = (v == CNT_MAX) ? CNT_MAX : v + 6'd1;
   endfunction

endpackage

>>> hw/rtl/irpd_step.sv
// ----------------------------------------------------------------------------
// IR pulse-distance receiver step logic
// Next state and result for one line sample, purely combinational.
// ----------------------------------------------------------------------------
module irpd_step (
   input  irpd_pkg::rx_state_type cur_state,
   input  irpd_pkg::cfg_type      cfg,
   input  logic                   line_level,
   output irpd_pkg::rx_state_type nxt_state,
   output irpd_pkg::rsp_type      rsp
);
   import irpd_pkg::*;

   rx_state_type nxt;
   logic         abort;
   logic         valid;
   logic         last;
   logic [7:0]   val;
   logic [2:0]   idx;

   always_comb begin
      nxt   = cur_state;
      abort = 1'b0;
      valid = 1'b0;
      last  = 1'b0;
      val   = 8'd0;
      idx   = 3'd0;

      case (cur_state.phase)
         PH_IDLE: begin
            if (!line_level) begin
               nxt.low_ticks  = 6'd0;
               nxt.high_ticks = 6'd0;
               nxt.phase      = PH_LEADER_LOW;
            end
         end
         PH_LEADER_LOW: begin
            if (!line_level) begin
               nxt.low_ticks = sat_inc(cur_state.low_ticks);
               if (nxt.low_ticks > cfg.leader_low_max) abort = 1'b1;
            end else if (cur_state.low_ticks < cfg.leader_low_min) begin
               abort = 1'b1;
            end else begin
               nxt.phase = PH_LEADER_HIGH;
            end
         end
         PH_LEADER_HIGH: begin
            if (!line_level) begin
               if (cur_state.high_ticks < cfg.leader_high_min) begin
                  abort = 1'b1;
               end else begin
                  nxt.phase        = PH_FIRST_LOW;
                  nxt.bit_taken    = 1'b0;
                  nxt.bit_counter  = 4'd0;
                  nxt.byte_counter = 3'd0;
                  nxt.ready_flag   = 1'b0;
                  nxt.low_ticks    = 6'd1;
                  nxt.high_ticks   = 6'd0;
               end
            end else begin
               nxt.high_ticks = sat_inc(cur_state.high_ticks);
               if (nxt.high_ticks > cfg.leader_high_max) abort = 1'b1;
            end
         end
         PH_FIRST_LOW: begin
            if (!line_level) begin
               nxt.low_ticks = sat_inc(cur_state.low_ticks);
            end else begin
               nxt.high_ticks = 6'd1;
               nxt.phase      = PH_DATA;
            end
         end
         PH_DATA: begin
            if (!line_level) begin
               nxt.low_ticks = sat_inc(cur_state.low_ticks);
               if (nxt.low_ticks > cfg.bit_low_max) abort = 1'b1;
               // classify the high period once, on the first low tick
               if (!abort && !cur_state.bit_taken) begin
                  if (cur_state.high_ticks >= cfg.one_high_min) begin
                     nxt.shift_byte  = {cur_state.shift_byte[6:0], 1'b1};
                     nxt.bit_taken   = 1'b1;
                     nxt.bit_counter = cur_state.bit_counter + 4'd1;
                  end else if (cur_state.high_ticks >= cfg.zero_high_min &&
                               cur_state.high_ticks <= cfg.zero_high_max) begin
                     nxt.shift_byte  = {cur_state.shift_byte[6:0], 1'b0};
                     nxt.bit_taken   = 1'b1;
                     nxt.bit_counter = cur_state.bit_counter + 4'd1;
                  end else begin
                     abort = 1'b1;
                  end
               end
               nxt.high_ticks = 6'd0;
               if (!abort && nxt.bit_counter >= BITS_PER_BYTE) begin
                  nxt.bit_counter = 4'd0;
                  valid           = 1'b1;
                  val             = nxt.shift_byte;
                  idx             = cur_state.byte_counter;
                  if ({1'b0, cur_state.byte_counter} + 4'd1 >= FRAME_BYTES_CNT) begin
                     last           = 1'b1;
                     nxt.phase      = PH_FRAME_END;
                     nxt.ready_flag = 1'b1;
                  end
                  nxt.byte_counter = cur_state.byte_counter + 3'd1;
               end
            end else begin
               nxt.high_ticks = sat_inc(cur_state.high_ticks);
               if (nxt.high_ticks > DATA_HIGH_LIMIT) abort = 1'b1;
               nxt.bit_taken = 1'b0;
               nxt.low_ticks = 6'd0;
            end
         end
         default: begin
            nxt.phase = PH_IDLE;
         end
      endcase

      if (abort) nxt.phase = PH_IDLE;
   end

   assign nxt_state        = nxt;
   assign rsp.byte_valid   = valid;
   assign rsp.byte_value   = val;
   assign rsp.byte_index   = idx;
   assign rsp.frame_last   = last;
   assign rsp.frame_abort  = abort;
   assign rsp.frame_ready  = nxt.ready_flag;
   assign rsp.receiving    = (nxt.phase != PH_IDLE);

endmodule

>>> hw/rtl/ir_pulse_distance_receiver.sv
// The result word of an accepted line sample word is registered.
// Throughput: one sample word per cycle while the result side is ready; the result register is refilled in the
// same cycle that it drains, so the stream runs back to back.
// Reset: synchronous, active high; returns the receiver to idle, clears all
// counters and flags and reloads every timing register with its default.
// ----------------------------------------------------------------------------
// IR pulse-distance receiver
// Times the leader of an infrared frame, decodes pulse-distance bits MSB
// first and emits one status word per line sample, carrying each byte.
// ----------------------------------------------------------------------------
module ir_pulse_distance_receiver (
   input  logic                          clock,
   input  logic                          reset,
   // Line sample stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [0] line_level, [7:1] zero
   // Result stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [15:0]                   rsp_tdata,   // [0] byte_valid, [8:1] byte_value,
                                                      // [11:9] byte_index,
                                                      // [12] frame_abort,
                                                      // [13] frame_ready,
                                                      // [14] receiving, [15] zero
   output logic                          rsp_tlast,   // frame_last
   // Timing register write port
   input  logic                          csr_we,
   input  logic [irpd_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [irpd_pkg::CSR_DW-1:0]   csr_wdata
);
   import irpd_pkg::*;

   rx_state_type state_ff, state_in;
   cfg_type      cfg_ff, cfg_in;
   rsp_type      rsp_ff, rsp_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         req_accept;

   // Take a new sample whenever the result slot is empty or drains this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   irpd_step u_step (
      .cur_state  (state_ff),
      .cfg        (cfg_ff),
      .line_level (req_tdata[0]),
      .nxt_state  (state_in),
      .rsp        (rsp_in)
   );

   // Timing registers: write the addressed one, hold the rest
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_LEADER_LOW_MIN:  cfg_in.leader_low_min  = csr_wdata;
            REG_LEADER_LOW_MAX:  cfg_in.leader_low_max  = csr_wdata;
            REG_LEADER_HIGH_MIN: cfg_in.leader_high_min = csr_wdata;
            REG_LEADER_HIGH_MAX: cfg_in.leader_high_max = csr_wdata;
            REG_BIT_LOW_MAX:     cfg_in.bit_low_max     = csr_wdata;
            REG_ZERO_HIGH_MIN:   cfg_in.zero_high_min   = csr_wdata;
            REG_ZERO_HIGH_MAX:   cfg_in.zero_high_max   = csr_wdata;
            REG_ONE_HIGH_MIN:    cfg_in.one_high_min    = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.leader_low_min  <= RST_LEADER_LOW_MIN;
         cfg_ff.leader_low_max  <= RST_LEADER_LOW_MAX;
         cfg_ff.leader_high_min <= RST_LEADER_HIGH_MIN;
         cfg_ff.leader_high_max <= RST_LEADER_HIGH_MAX;
         cfg_ff.bit_low_max     <= RST_BIT_LOW_MAX;
         cfg_ff.zero_high_min   <= RST_ZERO_HIGH_MIN;
         cfg_ff.zero_high_max   <= RST_ZERO_HIGH_MAX;
         cfg_ff.one_high_min    <= RST_ONE_HIGH_MIN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Receiver state advances only on an accepted sample word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase        <= PH_IDLE;
         state_ff.low_ticks    <= 6'd0;
         state_ff.high_ticks   <= 6'd0;
         state_ff.bit_counter  <= 4'd0;
         state_ff.byte_counter <= 3'd0;
         state_ff.shift_byte   <= 8'd0;
         state_ff.bit_taken    <= 1'b0;
         state_ff.ready_flag   <= 1'b0;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // Result slot: fill on accept, drop once taken
   assign rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_ff.frame_last;
   assign rsp_tdata  = {1'b0, rsp_ff.receiving, rsp_ff.frame_ready, rsp_ff.frame_abort,
                        rsp_ff.byte_index, rsp_ff.byte_value, rsp_ff.byte_valid};

`ifndef NO_ASSERTIONS
   // An abort suppresses any byte of the same tick
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.byte_valid && rsp_ff.frame_abort))
      else $error("byte presented on an aborted tick");

   // The last byte of a frame sits at the final index
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.frame_last) |->
         (rsp_ff.byte_valid && ({1'b0, rsp_ff.byte_index} + 4'd1 == FRAME_BYTES_CNT)))
      else $error("frame_last on a word that is not the final byte");

   // Closing byte moves the receiver to its end phase
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && rsp_in.frame_last) |=> (state_ff.phase == PH_FRAME_END))
      else $error("frame end not entered after last byte");

   // Status bits of a held word track the live state
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.receiving == (state_ff.phase != PH_IDLE) &&
                        rsp_ff.frame_ready == state_ff.ready_flag))
      else $error("result status out of step with receiver state");
`endif

endmodule

>>> tb/sv/ir_pulse_distance_receiver_test.sv
// ----------------------------------------------------------------------------
// IR pulse-distance receiver testbench
// Streams line samples into the receiver as whole frames (clean and faulty)
// and as noise, under several timing settings. Every result word is checked
// field by field against a sample-level tracker of the decoder state.
// ----------------------------------------------------------------------------
module ir_pulse_distance_receiver_test;
   import irpd_pkg::*;

   localparam int HOLD_OFF_CYCLES = 60;
   localparam int FRAME_BITS      = 8 * FRAME_BYTES;

   // Ways of spoiling a frame; the order matters for the random pick
   typedef enum int {
      FAULT_NONE,
      FAULT_LEADER_LOW_SHORT,
      FAULT_LEADER_LOW_LONG,
      FAULT_LEADER_HIGH_SHORT,
      FAULT_LEADER_HIGH_LONG,
      FAULT_BIT_LOW_LONG,
      FAULT_HIGH_LONG,
      FAULT_HIGH_GAP
   } fault_type;

   // -------------------------------------------------------------------------
   // Decoder state tracker: holds its own copy of the timing registers and the
   // receiver state, and queues one status word per accepted line sample.
   // -------------------------------------------------------------------------
   class ir_frame_tracker;
      cfg_type     timing;
      phase_type   phase;
      logic [5:0]  low_ticks;
      logic [5:0]  high_ticks;
      logic [3:0]  bit_num;
      logic [2:0]  byte_num;
      logic [7:0]  shift_byte;
      logic        bit_taken;
      logic        ready;
      rsp_type     status_due [$];
      int unsigned failures;

      function new();
         timing.leader_low_min  = RST_LEADER_LOW_MIN;
         timing.leader_low_max  = RST_LEADER_LOW_MAX;
         timing.leader_high_min = RST_LEADER_HIGH_MIN;
         timing.leader_high_max = RST_LEADER_HIGH_MAX;
         timing.bit_low_max     = RST_BIT_LOW_MAX;
         timing.zero_high_min   = RST_ZERO_HIGH_MIN;
         timing.zero_high_max   = RST_ZERO_HIGH_MAX;
         timing.one_high_min    = RST_ONE_HIGH_MIN;
         phase      = PH_IDLE;
         low_ticks  = '0;
         high_ticks = '0;
         bit_num    = '0;
         byte_num   = '0;
         shift_byte = '0;
         bit_taken  = 1'b0;
         ready      = 1'b0;
         failures   = 0;
      endfunction

      function logic [5:0] tick_up(logic [5:0] v);
         return (v == CNT_MAX) ? v : v + 6'd1;
      endfunction

      function void write_reg(logic [CSR_AW-1:0] idx, logic [CSR_DW-1:0] val);
         case (idx)
            REG_LEADER_LOW_MIN:  timing.leader_low_min  = val;
            REG_LEADER_LOW_MAX:  timing.leader_low_max  = val;
            REG_LEADER_HIGH_MIN: timing.leader_high_min = val;
            REG_LEADER_HIGH_MAX: timing.leader_high_max = val;
            REG_BIT_LOW_MAX:     timing.bit_low_max     = val;
            REG_ZERO_HIGH_MIN:   timing.zero_high_min   = val;
            REG_ZERO_HIGH_MAX:   timing.zero_high_max   = val;
            REG_ONE_HIGH_MIN:    timing.one_high_min    = val;
            default: ;
         endcase
      endfunction

      // Advance the decoder by one line sample and queue the status it gives
      function void note_sample(logic level);
         rsp_type st;
         logic    abort;
         st    = '0;
         abort = 1'b0;
         case (phase)
            PH_IDLE: begin
               if (!level) begin
                  low_ticks  = '0;
                  high_ticks = '0;
                  phase      = PH_LEADER_LOW;
               end
            end
            PH_LEADER_LOW: begin
               if (!level) begin
                  low_ticks = tick_up(low_ticks);
                  if (low_ticks > timing.leader_low_max) abort = 1'b1;
               end else if (low_ticks < timing.leader_low_min) begin
                  abort = 1'b1;
               end else begin
                  phase = PH_LEADER_HIGH;
               end
            end
            PH_LEADER_HIGH: begin
               if (!level) begin
                  if (high_ticks < timing.leader_high_min) begin
                     abort = 1'b1;
                  end else begin
                     // leader accepted: start a fresh frame, drop the ready flag
                     phase      = PH_FIRST_LOW;
                     bit_taken  = 1'b0;
                     bit_num    = '0;
                     byte_num   = '0;
                     ready      = 1'b0;
                     low_ticks  = 6'd1;
                     high_ticks = '0;
                  end
               end else begin
                  high_ticks = tick_up(high_ticks);
                  if (high_ticks > timing.leader_high_max) abort = 1'b1;
               end
            end
            PH_FIRST_LOW: begin
               // length of the first bit low goes unchecked
               if (!level) begin
                  low_ticks = tick_up(low_ticks);
               end else begin
                  high_ticks = 6'd1;
                  phase      = PH_DATA;
               end
            end
            PH_DATA: begin
               if (!level) begin
                  low_ticks = tick_up(low_ticks);
                  if (low_ticks > timing.bit_low_max) abort = 1'b1;
                  // the high just ended decides the bit on the first low tick
                  if (!abort && !bit_taken) begin
                     if (high_ticks >= timing.one_high_min) begin
                        shift_byte = {shift_byte[6:0], 1'b1};
                        bit_taken  = 1'b1;
                        bit_num    = bit_num + 4'd1;
                     end else if (high_ticks >= timing.zero_high_min &&
                                  high_ticks <= timing.zero_high_max) begin
                        shift_byte = {shift_byte[6:0], 1'b0};
                        bit_taken  = 1'b1;
                        bit_num    = bit_num + 4'd1;
                     end else begin
                        abort = 1'b1;
                     end
                  end
                  high_ticks = '0;
                  if (!abort && bit_num >= BITS_PER_BYTE) begin
                     bit_num         = '0;
                     st.byte_valid   = 1'b1;
                     st.byte_value   = shift_byte;
                     st.byte_index   = byte_num;
                     if (int'(byte_num) + 1 >= FRAME_BYTES) begin
                        st.frame_last = 1'b1;
                        phase         = PH_FRAME_END;
                        ready         = 1'b1;
                     end
                     byte_num = byte_num + 3'd1;
                  end
               end else begin
                  high_ticks = tick_up(high_ticks);
                  if (high_ticks > DATA_HIGH_LIMIT) abort = 1'b1;
                  bit_taken = 1'b0;
                  low_ticks = '0;
               end
            end
            default: phase = PH_IDLE;
         endcase
         if (abort) phase = PH_IDLE;
         st.frame_abort = abort;
         st.frame_ready = ready;
         st.receiving   = (phase != PH_IDLE);
         status_due.push_back(st);
      endfunction

      function void report(string what);
         failures++;
         if (failures <= 10) $display("[%0t] %s", $realtime, what);
      endfunction

      function void compare(string field, logic [7:0] got, logic [7:0] want);
         if (got !== want)
            report($sformatf("%s mismatch: expected %0h, got %0h", field, want, got));
      endfunction

      // Check one accepted result word against the oldest queued status
      function void check_status(logic [15:0] data, logic last);
         rsp_type want;
         if (status_due.size() == 0) begin
            report("result word with nothing outstanding");
            return;
         end
         want = status_due.pop_front();
         compare("byte_valid",  8'(data[0]),    8'(want.byte_valid));
         compare("byte_value",  data[8:1],      want.byte_value);
         compare("byte_index",  8'(data[11:9]), 8'(want.byte_index));
         compare("frame_last",  8'(last),       8'(want.frame_last));
         compare("frame_abort", 8'(data[12]),   8'(want.frame_abort));
         compare("frame_ready", 8'(data[13]),   8'(want.frame_ready));
         compare("receiving",   8'(data[14]),   8'(want.receiving));
      endfunction

      function void flush_leftovers();
         while (status_due.size() != 0) begin
            void'(status_due.pop_front());
            report("result word never arrived");
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Block under test
   // -------------------------------------------------------------------------
   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata  = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [15:0]       rsp_tdata;
   logic              rsp_tlast;
   logic              csr_we     = 1'b0;
   logic [CSR_AW-1:0] csr_addr   = '0;
   logic [CSR_DW-1:0] csr_wdata  = '0;

   ir_pulse_distance_receiver i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   ir_frame_tracker tracker = new();
   int unsigned     samples_sent     = 0;
   bit              idling_on        = 1'b1;
   bit              hold_off_request = 1'b0;

   // 20 time unit clock period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watch both channels at the rising edge. Check the result first: a word
   // leaving at this edge always belongs to a sample taken at an earlier one.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) tracker.check_status(rsp_tdata, rsp_tlast);
         if (req_tvalid && req_tready) tracker.note_sample(req_tdata[0]);
      end
   end

   // Result sink: random stalls, plus one long hold-off on request so that
   // the result register fills and the sample channel backs up.
   initial begin
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else if (idling_on && $urandom_range(9, 0) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(7, 1)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Give up after a generous fixed time
   initial begin
      #8_000_000;
      $display("ir_pulse_distance_receiver verification failed");
      $finish;
   end

   function automatic int unsigned cap(int unsigned v, int unsigned lim);
      return (v > lim) ? lim : v;
   endfunction

   function automatic cfg_type make_timing(int unsigned llmin, int unsigned llmax,
                                           int unsigned lhmin, int unsigned lhmax,
                                           int unsigned blmax, int unsigned zhmin,
                                           int unsigned zhmax, int unsigned ohmin);
      cfg_type c;
      c.leader_low_min  = 6'(llmin);
      c.leader_low_max  = 6'(llmax);
      c.leader_high_min = 6'(lhmin);
      c.leader_high_max = 6'(lhmax);
      c.bit_low_max     = 6'(blmax);
      c.zero_high_min   = 6'(zhmin);
      c.zero_high_max   = 6'(zhmax);
      c.one_high_min    = 6'(ohmin);
      return c;
   endfunction

   // Bytes of a frame, first byte in the top bits; lean on all-zero and all-one
   function automatic logic [FRAME_BITS-1:0] random_payload();
      logic [FRAME_BITS-1:0] p;
      for (int i = 0; i < FRAME_BYTES; i++) begin
         case ($urandom_range(7, 0))
            0:       p[8*i +: 8] = 8'h00;
            1:       p[8*i +: 8] = 8'hff;
            default: p[8*i +: 8] = 8'($urandom);
         endcase
      end
      return p;
   endfunction

   // Offer one line sample word and hold it until taken; called at a falling
   // edge, returns at a falling edge.
   task automatic send_sample(input logic level);
      if (idling_on && $urandom_range(11, 0) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(7, 1)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, level};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      samples_sent++;
      @(negedge clock);
   endtask

   task automatic send_run(input logic level, input int unsigned n);
      repeat (n) send_sample(level);
   endtask

   // Drive one frame shaped by the current timing, optionally spoilt at the
   // leader or at one randomly chosen data bit. Stop right after the fault.
   task automatic send_frame(input fault_type fault, input logic [FRAME_BITS-1:0] payload);
      cfg_type     t;
      int unsigned n;
      int unsigned spot;
      logic        bit_val;
      t    = tracker.timing;
      spot = $urandom_range(FRAME_BITS - 1, 0);
      send_run(1'b1, $urandom_range(4, 1));

      // leader low: n samples leave the low count at n-1
      if (fault == FAULT_LEADER_LOW_SHORT)
         n = (t.leader_low_min == 0) ? 1 : t.leader_low_min;
      else if (fault == FAULT_LEADER_LOW_LONG)
         n = t.leader_low_max + 2;
      else if (t.leader_low_max == CNT_MAX && $urandom_range(3, 0) == 0)
         n = $urandom_range(70, 64);   // run the counter into saturation
      else
         n = $urandom_range(cap(32'(t.leader_low_max), t.leader_low_min + 6) + 1,
                            t.leader_low_min + 1);
      send_run(1'b0, n);
      if (fault inside {FAULT_LEADER_LOW_SHORT, FAULT_LEADER_LOW_LONG}) return;

      // leader high: same counting, judged when the line drops again
      if (fault == FAULT_LEADER_HIGH_SHORT)
         n = (t.leader_high_min == 0) ? 1 : t.leader_high_min;
      else if (fault == FAULT_LEADER_HIGH_LONG)
         n = t.leader_high_max + 2;
      else if (t.leader_high_max == CNT_MAX && $urandom_range(3, 0) == 0)
         n = $urandom_range(70, 64);
      else
         n = $urandom_range(cap(32'(t.leader_high_max), t.leader_high_min + 6) + 1,
                            t.leader_high_min + 1);
      send_run(1'b1, n);
      if (fault == FAULT_LEADER_HIGH_SHORT) send_run(1'b0, 1);
      if (fault inside {FAULT_LEADER_HIGH_SHORT, FAULT_LEADER_HIGH_LONG}) return;

      // first bit low, then per bit a high that is decided by the next low
      send_run(1'b0, $urandom_range(3, 1));
      for (int k = 0; k < FRAME_BITS; k++) begin
         bit_val = payload[FRAME_BITS - 1 - k];
         if (bit_val)
            n = $urandom_range(cap(t.one_high_min + 2, 32'(DATA_HIGH_LIMIT)),
                               (t.one_high_min == 0) ? 1 : t.one_high_min);
         else
            n = $urandom_range(cap(32'(t.zero_high_max), 32'(DATA_HIGH_LIMIT)),
                               (t.zero_high_min == 0) ? 1 : t.zero_high_min);
         if (k == spot && fault == FAULT_HIGH_LONG)
            n = $urandom_range(12, DATA_HIGH_LIMIT + 1);
         if (k == spot && fault == FAULT_HIGH_GAP) begin
            // land between the zero window and the one threshold where possible
            if (t.zero_high_max + 1 < t.one_high_min)
               n = $urandom_range(cap(t.one_high_min - 1, 32'(DATA_HIGH_LIMIT)),
                                  t.zero_high_max + 1);
            else
               n = t.zero_high_max + 1;
         end
         send_run(1'b1, n);
         if (k == spot && fault == FAULT_HIGH_LONG) return;
         if (k == FRAME_BITS - 1)
            n = $urandom_range(2, 1);   // closing low: end phase, then idle
         else
            n = $urandom_range(cap((t.bit_low_max == 0) ? 1 : t.bit_low_max, 4), 1);
         if (k == spot && fault == FAULT_BIT_LOW_LONG)
            n = t.bit_low_max + 1 + $urandom_range(2, 0);
         send_run(1'b0, n);
         if (k == spot && fault != FAULT_NONE) return;
      end
   endtask

   task automatic send_noise(input int unsigned runs);
      repeat (runs) send_run(1'($urandom_range(1, 0)), $urandom_range(12, 1));
   endtask

   // Mostly clean frames, some spoilt ones, some noise, until the budget is spent
   task automatic send_mix(input int unsigned budget);
      int unsigned stop_at;
      int unsigned pick;
      stop_at = samples_sent + budget;
      while (samples_sent < stop_at) begin
         pick = $urandom_range(19, 0);
         if (pick < 13)
            send_frame(FAULT_NONE, random_payload());
         else if (pick < 17)
            send_frame(fault_type'($urandom_range(FAULT_HIGH_GAP, FAULT_LEADER_LOW_SHORT)),
                       random_payload());
         else
            send_noise($urandom_range(6, 1));
      end
   endtask

   // Stop offering, let every result word drain and the block settle
   task automatic settle();
      send_run(1'b1, 4);
      req_tvalid <= 1'b0;
      while (tracker.status_due.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // Write one register; the caller lowers the write enable after the last
   task automatic put_reg(input logic [CSR_AW-1:0] idx, input logic [CSR_DW-1:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      tracker.write_reg(idx, val);
      @(negedge clock);
   endtask

   task automatic load_timing(input cfg_type c);
      put_reg(REG_LEADER_LOW_MIN,  c.leader_low_min);
      put_reg(REG_LEADER_LOW_MAX,  c.leader_low_max);
      put_reg(REG_LEADER_HIGH_MIN, c.leader_high_min);
      put_reg(REG_LEADER_HIGH_MAX, c.leader_high_max);
      put_reg(REG_BIT_LOW_MAX,     c.bit_low_max);
      put_reg(REG_ZERO_HIGH_MIN,   c.zero_high_min);
      put_reg(REG_ZERO_HIGH_MAX,   c.zero_high_max);
      put_reg(REG_ONE_HIGH_MIN,    c.one_high_min);
      csr_we <= 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset timing: one clean frame of edge-case bytes, then each way the
      // leader can be rejected.
      send_frame(FAULT_NONE, {8'h00, 8'hff, 8'h01, 8'hfe, 8'ha5, 8'h5a});
      send_frame(FAULT_LEADER_LOW_SHORT, random_payload());
      send_frame(FAULT_LEADER_LOW_LONG, random_payload());
      send_frame(FAULT_LEADER_HIGH_SHORT, random_payload());
      send_frame(FAULT_LEADER_HIGH_LONG, random_payload());
      settle();

      // Fast timing; hold the sink off once during a frame
      load_timing(make_timing(2, 5, 2, 5, 2, 1, 1, 3));
      send_mix(40);
      hold_off_request = 1'b1;
      send_frame(FAULT_NONE, random_payload());
      settle();

      // Widest bounds: maximum registers never reject once the counters saturate
      load_timing(make_timing(0, 63, 0, 63, 63, 0, 63, 8));
      send_frame(FAULT_LEADER_LOW_LONG, random_payload());
      settle();

      // All bounds zero: every data bit low is too long
      load_timing(make_timing(0, 0, 0, 0, 0, 0, 0, 0));
      send_mix(30);
      settle();

      // Random bounds with an unreachable one threshold
      load_timing(make_timing($urandom_range(63, 0), $urandom_range(63, 0),
                              $urandom_range(63, 0), $urandom_range(63, 0),
                              $urandom_range(63, 0), $urandom_range(63, 0),
                              $urandom_range(63, 0), 63));
      send_mix(40);
      settle();

      // Last stretch back to back, no idling on either side
      load_timing(make_timing(1, 3, 3, 6, 3, 2, 3, 5));
      idling_on = 1'b0;
      send_frame(FAULT_NONE, random_payload());
      send_mix(10);
      send_run(1'b1, 4);
      req_tvalid <= 1'b0;

      for (int w = 0; w < 1000 && tracker.status_due.size() != 0; w++) @(negedge clock);
      repeat (4) @(negedge clock);
      tracker.flush_leftovers();

      if (tracker.failures == 0)
         $display("ir_pulse_distance_receiver verification clean");
      else
         $display("ir_pulse_distance_receiver verification failed");
      $finish;
   end

endmodule
